[rtl/eghb_pkg.sv]
// Package for the encoder / gyro heading blend unit.
// Holds field widths, turn and blend constants, mode and register codes,
// the pipeline tag type and the divide-by-1000 helper. No dependencies.
package eghb_pkg;

    localparam int ENC_W      = 32;
    localparam int GYRO_W     = 20;
    localparam int WGT_W      = 10;
    localparam int REM_W      = 11;
    localparam int GD_W       = 19;
    localparam int DIFF_W     = 22;
    localparam int SUM_W      = 36;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam int MODE_W     = 2;

    // Seven working stages plus the result register.
    localparam int PIPE_STAGES = 7;
    localparam int PIPE_DEPTH  = PIPE_STAGES + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_NEGATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT = 1'b1;

    // Per-item update modes.
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;   // latch references only
    localparam logic [MODE_W-1:0] MODE_ENC   = 2'd1;   // encoder delta only
    localparam logic [MODE_W-1:0] MODE_BLEND = 2'd2;   // weighted blend

    // Permille blend scale, also the largest legal weight.
    localparam logic [WGT_W-1:0] BLEND_SCALE = 10'd1000;

    // Turn constants in millidegrees and the wrap thresholds.
    localparam logic signed [DIFF_W-1:0] HALF_TURN = 22'sd180000;
    localparam logic signed [DIFF_W-1:0] FULL_TURN = 22'sd360000;
    localparam logic signed [DIFF_W-1:0] TURNS_2   = FULL_TURN + FULL_TURN;
    localparam logic signed [DIFF_W-1:0] TURNS_3   = TURNS_2 + FULL_TURN;
    localparam logic signed [DIFF_W-1:0] TURN_LIM2 = HALF_TURN + FULL_TURN;
    localparam logic signed [DIFF_W-1:0] TURN_LIM3 = TURN_LIM2 + FULL_TURN;

    // Bias that makes (gyro delta - encoder delta) non-negative; a multiple of 1000.
    localparam logic [32:0] DH_OFFSET = 33'd2147664000;
    localparam logic [22:0] DH_BIAS   = 23'(DH_OFFSET / 1000);

    // floor(x / 125) = (x * RECIP_125) >> RECIP_SHIFT for any x below 2^30.
    localparam logic [30:0] RECIP_125   = 31'd1099511628;
    localparam int          RECIP_SHIFT = 37;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic                    trk;
        logic signed [ENC_W-1:0] enc_delta;
    } tag_t;

    // Floor division of an unsigned 33-bit value by 1000: drop 3 bits, then /125.
    function automatic logic [23:0] div_1000(input logic [32:0] x);
        logic [60:0] prod;
        prod = 61'(x[32:3]) * 61'(RECIP_125);
        return prod[60:RECIP_SHIFT];
    endfunction

endpackage

[rtl/encoder_gyro_heading_blend_unit.sv]
// Top level of the encoder / gyro heading blend unit.
// Depends on eghb_pkg for widths, constants, codes and the tag type.
//
// Fuses an encoder heading and a gyro heading (millidegrees) into one 32-bit
// wrapping heading. Every accepted item gives exactly one result item. The
// unit takes one item per clock when the result side keeps up, and up to 8
// items are in flight. The pipeline depth comes from the registered
// reciprocal multiplies that divide the blend by 1000 and from the weight
// multiply; the carried remainder and the heading accumulator are resolved
// in the last stage, so items may follow each other without gaps. The first
// item after reset only latches references. Write configuration only while
// no item is in flight.
module encoder_gyro_heading_blend_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [eghb_pkg::ENC_W-1:0]    s_encoder_heading,
    input  logic signed [eghb_pkg::GYRO_W-1:0]   s_gyro_heading_raw,
    input  logic                                 s_gyro_ok,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [eghb_pkg::ENC_W-1:0]    m_heading,
    output logic                                 m_tracking_gyro,
    input  logic                                 cfg_wr_en,
    input  logic [eghb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [eghb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import eghb_pkg::*;

    // Configuration.
    logic                     negate_reg;
    logic [WGT_W-1:0]         weight_reg;

    // Item-to-item state updated at accept.
    logic                     started_reg;
    logic                     tracking_reg;
    logic signed [ENC_W-1:0]  prev_enc_reg;
    logic signed [GYRO_W-1:0] prev_gyro_reg;

    // State resolved in the last stage.
    logic [ENC_W-1:0]         fused_reg;
    logic signed [REM_W-1:0]  carry_reg;

    // Pipeline control: ready per stage, index PIPE_DEPTH is the result register.
    logic [PIPE_STAGES:1]     vld_reg;
    logic [PIPE_DEPTH:1]      rdy;
    tag_t                     tag_reg [1:PIPE_STAGES];

    // Stage data.
    logic signed [GD_W-1:0]   gd1_reg;
    logic [32:0]              v2_reg;
    logic [23:0]              q3_reg;
    logic [9:0]               lo3_reg;
    logic [9:0]               dl4_reg;
    logic signed [22:0]       dh4_reg;
    logic signed [33:0]       pa5_reg;
    logic [19:0]              pb5_reg;
    logic signed [33:0]       pa6_reg;
    logic [9:0]               pblo6_reg;
    logic [9:0]               pbq6_reg;
    logic signed [SUM_W-1:0]  s7_reg;
    logic [9:0]               pr7_reg;

    // Result register.
    logic                     m_valid_reg;
    logic signed [ENC_W-1:0]  m_heading_reg;
    logic                     m_trk_reg;

    // Accept-side logic.
    logic                     s_acc;
    logic signed [GYRO_W-1:0] gyro_corr;
    logic signed [DIFF_W-1:0] gyro_diff;
    logic signed [DIFF_W-1:0] gyro_wrap;
    tag_t                     tag_in;

    // Last-stage logic.
    logic signed [11:0]       rsum;
    logic signed [1:0]        adj;
    logic [9:0]               rfix;
    logic signed [SUM_W-1:0]  qfl;
    logic signed [SUM_W-1:0]  quo;
    logic signed [REM_W-1:0]  rem;
    logic [ENC_W-1:0]         fused_next;
    logic signed [REM_W-1:0]  carry_next;

    // ------------------------------------------------------------------
    // Handshake: a stage takes new content when it is empty or drains.
    // ------------------------------------------------------------------
    always_comb begin
        rdy[PIPE_DEPTH] = !m_valid_reg || m_ready;
        for (int k = PIPE_STAGES; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_ready = rdy[1];
    assign s_acc   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Configuration writes; clamp the weight to full scale.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            negate_reg <= 1'b0;
            weight_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GYRO_NEGATE: negate_reg <= cfg_data[0];
                REG_GYRO_WEIGHT: weight_reg <= (cfg_data > BLEND_SCALE) ? BLEND_SCALE
                                                                         : cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Accept: sign-correct the gyro, wrap its delta into half a turn,
    // take the encoder delta and pick the update mode.
    // ------------------------------------------------------------------
    always_comb begin
        // Negation wraps within the gyro field width.
        gyro_corr = negate_reg ? -s_gyro_heading_raw : s_gyro_heading_raw;
        gyro_diff = DIFF_W'(gyro_corr) - DIFF_W'(prev_gyro_reg);

        // At most three full-turn corrections cover every gyro bit pattern.
        if (gyro_diff > TURN_LIM3) begin
            gyro_wrap = gyro_diff - TURNS_3;
        end else if (gyro_diff > TURN_LIM2) begin
            gyro_wrap = gyro_diff - TURNS_2;
        end else if (gyro_diff > HALF_TURN) begin
            gyro_wrap = gyro_diff - FULL_TURN;
        end else if (gyro_diff < -TURN_LIM3) begin
            gyro_wrap = gyro_diff + TURNS_3;
        end else if (gyro_diff < -TURN_LIM2) begin
            gyro_wrap = gyro_diff + TURNS_2;
        end else if (gyro_diff < -HALF_TURN) begin
            gyro_wrap = gyro_diff + FULL_TURN;
        end else begin
            gyro_wrap = gyro_diff;
        end

        tag_in.enc_delta = s_encoder_heading - prev_enc_reg;
        // Tracking after this item always follows gyro_ok.
        tag_in.trk       = s_gyro_ok;
        if (!started_reg) begin
            tag_in.mode = MODE_FIRST;
        end else if (!s_gyro_ok || !tracking_reg) begin
            // Gyro lost, or just regained: encoder only.
            tag_in.mode = MODE_ENC;
        end else begin
            tag_in.mode = MODE_BLEND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            tracking_reg <= 1'b0;
        end else if (s_acc) begin
            started_reg  <= 1'b1;
            tracking_reg <= s_gyro_ok;
        end
    end

    // Re-latch the gyro reference on the first item and whenever it is valid.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            prev_enc_reg <= s_encoder_heading;
            if (!started_reg || s_gyro_ok) begin
                prev_gyro_reg <= gyro_corr;
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid bits and tags ride along the stages.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[1]) begin
                vld_reg[1] <= s_valid;
            end
            for (int k = 2; k <= PIPE_STAGES; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            tag_reg[1] <= tag_in;
        end
        for (int k = 2; k <= PIPE_STAGES; k++) begin
            if (rdy[k]) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Blend arithmetic. The blend numerator is rewritten as
    //   1000*e + w*(g - e) + carry,
    // and w*(g - e) is split as 1000*Pq + Pr with 0 <= Pr < 1000.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        // Stage 1: wrapped gyro delta.
        if (rdy[1]) begin
            gd1_reg <= GD_W'(gyro_wrap);
        end
        // Stage 2: biased difference d = g - e, always non-negative.
        if (rdy[2]) begin
            v2_reg <= 33'(34'(gd1_reg) - 34'(tag_reg[1].enc_delta) + 34'(DH_OFFSET));
        end
        // Stage 3: d / 1000 by reciprocal multiply.
        if (rdy[3]) begin
            q3_reg  <= div_1000(v2_reg);
            lo3_reg <= v2_reg[9:0];
        end
        // Stage 4: floor quotient and remainder of d.
        if (rdy[4]) begin
            dl4_reg <= lo3_reg - 10'(q3_reg[9:0] * BLEND_SCALE);
            dh4_reg <= 23'($signed({1'b0, q3_reg}) - $signed({2'b00, DH_BIAS}));
        end
        // Stage 5: weight products.
        if (rdy[5]) begin
            pa5_reg <= 34'(dh4_reg) * 34'($signed({1'b0, weight_reg}));
            pb5_reg <= 20'(dl4_reg) * 20'(weight_reg);
        end
        // Stage 6: split the low product by 1000.
        if (rdy[6]) begin
            pa6_reg   <= pa5_reg;
            pblo6_reg <= pb5_reg[9:0];
            pbq6_reg  <= 10'(div_1000(33'(pb5_reg)));
        end
        // Stage 7: quotient base e + Pq and remainder Pr.
        if (rdy[7]) begin
            s7_reg  <= SUM_W'(pa6_reg) + SUM_W'(tag_reg[6].enc_delta) + SUM_W'(pbq6_reg);
            pr7_reg <= pblo6_reg - 10'(pbq6_reg * BLEND_SCALE);
        end
    end

    // ------------------------------------------------------------------
    // Last stage: fold in the carried remainder, turn the floor quotient
    // into a truncating one and advance the heading.
    // ------------------------------------------------------------------
    always_comb begin
        rsum = $signed({2'b00, pr7_reg}) + 12'(carry_reg);
        if (rsum < 0) begin
            adj  = -2'sd1;
            rfix = 10'(rsum + 12'sd1000);
        end else if (rsum >= 12'sd1000) begin
            adj  = 2'sd1;
            rfix = 10'(rsum - 12'sd1000);
        end else begin
            adj  = 2'sd0;
            rfix = rsum[9:0];
        end

        qfl = s7_reg + SUM_W'(adj);
        // Negative with a remainder: round toward zero.
        if (qfl < 0 && rfix != '0) begin
            quo = qfl + 36'sd1;
            rem = $signed({1'b0, rfix}) - 11'sd1000;
        end else begin
            quo = qfl;
            rem = $signed({1'b0, rfix});
        end

        case (tag_reg[PIPE_STAGES].mode)
            MODE_BLEND: begin
                fused_next = fused_reg + quo[ENC_W-1:0];
                carry_next = rem;
            end
            MODE_ENC: begin
                // Keep the carry while the gyro is out.
                fused_next = fused_reg + tag_reg[PIPE_STAGES].enc_delta;
                carry_next = carry_reg;
            end
            default: begin
                fused_next = fused_reg;
                carry_next = carry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fused_reg   <= '0;
            carry_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else if (rdy[PIPE_DEPTH]) begin
            m_valid_reg <= vld_reg[PIPE_STAGES];
            if (vld_reg[PIPE_STAGES]) begin
                fused_reg <= fused_next;
                carry_reg <= carry_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[PIPE_DEPTH] && vld_reg[PIPE_STAGES]) begin
            m_heading_reg <= fused_next;
            m_trk_reg     <= tag_reg[PIPE_STAGES].trk;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_heading       = m_heading_reg;
    assign m_tracking_gyro = m_trk_reg;

endmodule

[rtl/eghb_checker.sv]
// Port-level checker for the encoder / gyro heading blend unit, bound to the top.
// Depends on eghb_pkg for widths and the pipeline depth.
module eghb_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [eghb_pkg::ENC_W-1:0]  m_heading,
    input logic                               m_tracking_gyro
);
    import eghb_pkg::*;

    // Items accepted but not yet delivered.
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;

    assign cnt_next = cnt_reg + 4'(s_valid && s_ready) - 4'(m_valid && m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Hold a stalled result.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_heading) && $stable(m_tracking_gyro))
        else $error("stalled result changed");

    // An empty result register means every stage can take an item.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Never show a result without an item behind it.
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> cnt_reg != '0)
        else $error("result without accepted item");

    // In-flight items never exceed the pipeline depth.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 4'(PIPE_DEPTH))
        else $error("too many items in flight");

endmodule

bind encoder_gyro_heading_blend_unit eghb_checker u_eghb_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for encoder_gyro_heading_blend_unit.
// Drives samples over valid/ready, predicts each fused heading in-bench and
// checks every result in order. Depends on eghb_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module tb_top;
    import eghb_pkg::*;

    // Arithmetic constants of the blend, kept as plain ints so that all
    // prediction math stays signed.
    localparam int PERMILLE  = 1000;
    localparam int HALF_MDEG = int'(HALF_TURN);
    localparam int FULL_MDEG = int'(FULL_TURN);
    localparam int GYRO_SPAN = 360000;

    localparam int ITEMS_PER_PHASE = 246;
    localparam int SETTLE_CYCLES   = 2 * PIPE_DEPTH;
    localparam int RUN_LIMIT       = 500000;

    typedef struct {
        logic signed [ENC_W-1:0]  enc;
        logic signed [GYRO_W-1:0] gyro;
        logic                     ok;
    } sample_t;

    typedef struct {
        logic signed [ENC_W-1:0] heading;
        logic                    tracking;
    } fused_t;

    // Clock and reset.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #1 aclk = ~aclk;

    // Every block input starts from a known value.
    logic                        s_valid            = 1'b0;
    logic                        s_ready;
    logic signed [ENC_W-1:0]     s_encoder_heading  = '0;
    logic signed [GYRO_W-1:0]    s_gyro_heading_raw = '0;
    logic                        s_gyro_ok          = 1'b0;
    logic                        m_valid;
    logic                        m_ready            = 1'b0;
    logic signed [ENC_W-1:0]     m_heading;
    logic                        m_tracking_gyro;
    logic                        cfg_wr_en          = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index          = '0;
    logic [CFG_DATA_W-1:0]       cfg_data           = '0;

    encoder_gyro_heading_blend_unit i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_encoder_heading  (s_encoder_heading),
        .s_gyro_heading_raw (s_gyro_heading_raw),
        .s_gyro_ok          (s_gyro_ok),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_heading          (m_heading),
        .m_tracking_gyro    (m_tracking_gyro),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // Samples waiting to be sent, and headings the unit still owes us.
    sample_t sample_q[$];
    fused_t  heading_q[$];

    // Shadow copy of the configuration registers.
    bit neg_gyro   = 1'b0;
    int gyro_share = 0;

    // Shadow copy of the fusion state, all zero out of reset.
    logic [ENC_W-1:0]         est_heading = '0;
    logic [ENC_W-1:0]         last_enc    = '0;
    logic signed [GYRO_W-1:0] last_gyro   = '0;
    int                       blend_carry = 0;
    bit                       have_ref    = 1'b0;
    bit                       gyro_locked = 1'b0;

    // Idling control: gap counters, no-idle run lengths, and a flag that
    // turns all idling off for the closing phase.
    int send_gap  = 0;
    int send_run  = 0;
    int recv_gap  = 0;
    int recv_run  = 0;
    int idle_pick;
    int stall_pick;
    bit steady    = 1'b0;

    int      fails = 0;
    int      cycle_count = 0;
    sample_t on_wire;
    fused_t  want;

    // Random-walk state used to build plausible sample streams.
    logic [ENC_W-1:0] walk_enc = '0;
    int               walk_gyro = 0;
    bit               walk_ok = 1'b1;

    // Advance the shadow state by one accepted sample and return the heading
    // the unit must report for it.
    function automatic fused_t advance_heading(sample_t smp);
        logic signed [GYRO_W-1:0] g;
        logic [ENC_W-1:0]         enc_step;
        int                       gd;
        longint                   num;
        longint                   quot;
        fused_t                   res;
        // Negation wraps inside 20 bits, so the most negative value maps to itself.
        g = neg_gyro ? -smp.gyro : smp.gyro;
        if (!have_ref) begin
            // First sample only latches both references.
            last_enc    = smp.enc;
            last_gyro   = g;
            have_ref    = 1'b1;
            gyro_locked = smp.ok;
        end else begin
            enc_step = smp.enc - last_enc;
            last_enc = smp.enc;
            if (!smp.ok) begin
                // Gyro lost: encoder only, carry left alone.
                est_heading = est_heading + enc_step;
                gyro_locked = 1'b0;
            end else if (!gyro_locked) begin
                // Gyro back: re-latch its reference, encoder only this time.
                last_gyro   = g;
                est_heading = est_heading + enc_step;
                gyro_locked = 1'b1;
            end else begin
                gd = int'(g) - int'(last_gyro);
                while (gd > HALF_MDEG)
                    gd -= FULL_MDEG;
                while (gd < -HALF_MDEG)
                    gd += FULL_MDEG;
                last_gyro = g;
                num = longint'(gyro_share) * longint'(gd)
                    + longint'(PERMILLE - gyro_share) * longint'($signed(enc_step))
                    + longint'(blend_carry);
                // Signed division truncates toward zero; the remainder keeps the sign.
                quot        = num / PERMILLE;
                blend_carry = int'(num % PERMILLE);
                est_heading = est_heading + quot[ENC_W-1:0];
            end
        end
        res.heading  = est_heading;
        res.tracking = gyro_locked;
        return res;
    endfunction

    function automatic void add_sample(logic [ENC_W-1:0] enc, int gyro, bit ok);
        sample_t smp;
        smp.enc  = enc;
        smp.gyro = gyro[GYRO_W-1:0];
        smp.ok   = ok;
        sample_q.push_back(smp);
    endfunction

    // Queue n samples. Most follow a smooth walk with occasional gyro
    // dropouts; the rest are jumps, pure noise and field extremes.
    function automatic void make_samples(int n);
        int             r;
        int             pick;
        logic [ENC_W-1:0] enc_x[4];
        int             gyro_x[5];
        enc_x  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        gyro_x = '{-GYRO_SPAN, GYRO_SPAN, 0, HALF_MDEG, -HALF_MDEG};
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            // Dropouts are short; recovery is likely within a few samples.
            if (walk_ok)
                walk_ok = ($urandom_range(0, 99) >= 5);
            else
                walk_ok = ($urandom_range(0, 99) < 30);
            if (r < 70) begin
                walk_enc  = walk_enc + $urandom_range(0, 8000) - 4000;
                walk_gyro = walk_gyro + int'($urandom_range(0, 40000)) - 20000;
                if (walk_gyro > GYRO_SPAN)
                    walk_gyro -= 2 * GYRO_SPAN;
                if (walk_gyro < -GYRO_SPAN)
                    walk_gyro += 2 * GYRO_SPAN;
                add_sample(walk_enc, walk_gyro, walk_ok);
            end else if (r < 85) begin
                walk_enc  = walk_enc + $urandom;
                walk_gyro = int'($urandom_range(0, 2 * GYRO_SPAN)) - GYRO_SPAN;
                add_sample(walk_enc, walk_gyro, walk_ok);
            end else if (r < 95) begin
                add_sample($urandom, int'($urandom_range(0, 2 * GYRO_SPAN)) - GYRO_SPAN,
                           $urandom_range(0, 1));
            end else begin
                pick = $urandom_range(0, 4);
                add_sample(enc_x[$urandom_range(0, 3)], gyro_x[pick], walk_ok);
            end
        end
    endfunction

    // Write one register and mirror it into the shadow configuration.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_GYRO_NEGATE)
            neg_gyro = val[0];
        else
            gyro_share = (val[CFG_DATA_W-1:0] > PERMILLE) ? PERMILLE
                                                          : int'(val[CFG_DATA_W-1:0]);
    endtask

    // Hold until every queued sample is sent and every heading is back, then
    // let the pipeline run dry. Sample on the falling edge so that the
    // sender's updates from the rising edge are already visible.
    task automatic wait_quiet();
        while (sample_q.size() != 0 || s_valid || heading_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Sender: present the next sample whenever the channel is free, predict
    // on acceptance, and idle in random bursts between items.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                heading_q.push_back(advance_heading(on_wire));
            if (!s_valid || s_ready) begin
                if (!steady && send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    on_wire = sample_q.pop_front();
                    s_encoder_heading  <= on_wire.enc;
                    s_gyro_heading_raw <= on_wire.gyro;
                    s_gyro_ok          <= on_wire.ok;
                    s_valid            <= 1'b1;
                    // Plan the gap after this item, or a stretch with none.
                    if (!steady) begin
                        if (send_run > 0) begin
                            send_run--;
                        end else begin
                            idle_pick = $urandom_range(0, 9);
                            if (idle_pick < 3)
                                send_gap = $urandom_range(1, 15);
                            else if (idle_pick < 5)
                                send_run = $urandom_range(10, 60);
                        end
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted result against the oldest prediction and
    // stall in random bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (heading_q.size() == 0) begin
                    fails++;
                    $error("unexpected result: heading %0d tracking_gyro %0b",
                           m_heading, m_tracking_gyro);
                end else begin
                    want = heading_q.pop_front();
                    if (m_heading !== want.heading) begin
                        fails++;
                        $error("heading: expected %0d, actual %0d",
                               want.heading, m_heading);
                    end
                    if (m_tracking_gyro !== want.tracking) begin
                        fails++;
                        $error("tracking_gyro: expected %0b, actual %0b",
                               want.tracking, m_tracking_gyro);
                    end
                end
            end
            if (steady) begin
                m_ready <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (recv_run > 0) begin
                    recv_run--;
                end else begin
                    stall_pick = $urandom_range(0, 9);
                    if (stall_pick < 3)
                        recv_gap = $urandom_range(1, 15);
                    else if (stall_pick < 5)
                        recv_run = $urandom_range(10, 60);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, part one: odd weight so that the carry is live.
        write_reg(REG_GYRO_NEGATE, 0);
        write_reg(REG_GYRO_WEIGHT, 333);
        add_sample(32'h7FFF_FFFF, GYRO_SPAN, 1'b1);     // first sample latches only
        add_sample(32'h8000_0000, -GYRO_SPAN, 1'b1);    // encoder wraps, gyro needs two turns
        add_sample(32'h8000_1388, HALF_MDEG, 1'b1);     // gyro delta lands on +half turn
        add_sample(32'h8000_1388, -HALF_MDEG, 1'b1);    // full-turn delta folds to zero
        add_sample(32'hFFFF_FFFF, 123457, 1'b0);        // gyro lost, carry must hold
        add_sample(32'h0000_0000, -GYRO_SPAN, 1'b0);
        add_sample(32'h0000_03E7, 100000, 1'b1);        // gyro back, reference re-latched
        add_sample(32'h0000_0400, 279999, 1'b1);        // just under half a turn
        add_sample(32'h7FFF_FFFF, -100002, 1'b1);       // one correction upward
        add_sample(32'h8000_0000, 0, 1'b1);
        wait_quiet();

        // Directed, part two: negated gyro, weight written above full scale.
        write_reg(REG_GYRO_NEGATE, 1);
        write_reg(REG_GYRO_WEIGHT, 1023);
        add_sample(32'h8000_0000, -524288, 1'b1);       // most negative value negates to itself
        add_sample(32'h7FFF_FFFF, GYRO_SPAN, 1'b1);
        add_sample(32'h8000_0000, -GYRO_SPAN, 1'b1);
        add_sample(32'h0000_0000, 1, 1'b0);
        add_sample(32'h0000_0000, -524288, 1'b1);
        add_sample(32'hFFFF_FFFF, 359999, 1'b1);
        add_sample(32'h0000_0001, 0, 1'b1);
        wait_quiet();

        // Random phases across the weight range.
        write_reg(REG_GYRO_NEGATE, 0);
        write_reg(REG_GYRO_WEIGHT, 0);
        make_samples(ITEMS_PER_PHASE);
        wait_quiet();

        write_reg(REG_GYRO_NEGATE, 1);
        write_reg(REG_GYRO_WEIGHT, $urandom_range(1, 999));
        make_samples(ITEMS_PER_PHASE / 2);
        // Hold the sender mid-phase until the unit has drained.
        wait_quiet();
        make_samples(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
        wait_quiet();

        write_reg(REG_GYRO_NEGATE, 0);
        write_reg(REG_GYRO_WEIGHT, PERMILLE);
        make_samples(ITEMS_PER_PHASE);
        wait_quiet();

        write_reg(REG_GYRO_NEGATE, 1);
        write_reg(REG_GYRO_WEIGHT, $urandom_range(0, 1023));
        make_samples(ITEMS_PER_PHASE);
        wait_quiet();

        // Closing phase at full rate on both sides.
        write_reg(REG_GYRO_NEGATE, 0);
        write_reg(REG_GYRO_WEIGHT, $urandom_range(1, 999));
        steady = 1'b1;
        make_samples(ITEMS_PER_PHASE);
        wait_quiet();

        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
